@@ src/ntob_pkg.sv @@
// Shared types and constants of the noise texture overlay blend core.
package ntob_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_NOISE_PERCENT  = 3'd0;
  localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_CLIP_LEFT      = 3'd3;
  localparam logic [2:0] REG_CLIP_TOP       = 3'd4;
  localparam logic [2:0] REG_CLIP_RIGHT     = 3'd5;
  localparam logic [2:0] REG_CLIP_BOTTOM    = 3'd6;

  localparam int unsigned APB_ADDR_BITS = 5;

  // Blend arithmetic constants.
  localparam logic [6:0] PCT_MAX      = 7'd100;
  localparam logic [7:0] NEUTRAL      = 8'd128;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  // floor(x / 100) = (x * 5243) >> 19 for x <= 25500.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  // floor(y / 255) = (y * 32897) >> 23 for y <= 64770.
  localparam logic [15:0] RECIP_255   = 16'd32897;

  // Register stages inside the channel blend unit.
  localparam int unsigned BLEND_STAGES = 4;

  // Item information that rides alongside the texture lookup.
  typedef struct packed {
    logic        load;     // texel load, never produces a result
    logic        we;       // texel load whose coordinates are in range
    logic        in_clip;  // pixel lies inside the clip window
    logic [31:0] pix;      // pixel or texel payload
  } side_t;

endpackage

@@ src/ntob_mod.sv @@
// Pipelined restoring remainder unit: one dividend bit per stage.
module ntob_mod #(
  parameter int unsigned DIVIDEND_BITS = 12,
  parameter int unsigned DIVISOR_BITS  = 9,
  parameter int unsigned REM_BITS      = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic [REM_BITS-1:0]      remainder
);

  logic [DIVISOR_BITS-1:0]  rem_q [0:DIVIDEND_BITS-1];
  logic [DIVIDEND_BITS-1:0] dvd_q [0:DIVIDEND_BITS-2];

  for (genvar k = 0; k < DIVIDEND_BITS; k++) begin : g_stage
    logic [DIVISOR_BITS-1:0]  r_prev;
    logic [DIVIDEND_BITS-1:0] d_prev;
    logic [DIVISOR_BITS:0]    trial;

    // Previous partial remainder and the dividend bits still to consume.
    if (k == 0) begin : g_first
      assign r_prev = '0;
      assign d_prev = dividend;
    end else begin : g_next
      assign r_prev = rem_q[k-1];
      assign d_prev = dvd_q[k-1];
    end

    // Shift in the next dividend bit and subtract the divisor if it fits.
    assign trial = {r_prev, d_prev[DIVIDEND_BITS-1-k]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, divisor}) begin
          rem_q[k] <= DIVISOR_BITS'(trial - {1'b0, divisor});
        end else begin
          rem_q[k] <= DIVISOR_BITS'(trial);
        end
      end
    end

    if (k < DIVIDEND_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dvd_q[k] <= d_prev;
        end
      end
    end
  end

  // The remainder is below the divisor, so it fits the texel index width.
  assign remainder = rem_q[DIVIDEND_BITS-1][REM_BITS-1:0];

endmodule

@@ src/ntob_blend.sv @@
// One color channel: pull noise toward grey, then overlay-blend with the pixel.
module ntob_blend (
  input  logic       clk,
  input  logic       en,
  input  logic [6:0] p,
  input  logic [7:0] c,
  input  logic [7:0] n,
  output logic [7:0] r
);

  logic [14:0] x1;
  logic [7:0]  c1;
  logic [26:0] q2;
  logic [7:0]  c2;
  logic [15:0] y3;
  logic        hi3;
  logic [30:0] z4;
  logic        hi4;

  logic [14:0] np_prod;
  logic [14:0] grey;
  logic        c2_hi;
  logic [7:0]  m2;
  logic [7:0]  mul_a;
  logic [7:0]  mul_b;
  logic [7:0]  quot;

  function automatic logic [6:0] PCT_MAX_SUB(input logic [6:0] pv);
    return ntob_pkg::PCT_MAX - pv;
  endfunction

  // Stage 1: weighted sum n*p + 128*(100-p).
  assign np_prod = 15'(15'(n) * 15'(p));
  assign grey    = 15'({PCT_MAX_SUB(p), 7'd0});

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= np_prod + grey;
      c1 <= c;
    end
  end

  // Stage 2: divide by 100 through the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      q2 <= 27'(27'(x1) * 27'(ntob_pkg::RECIP_100));
      c2 <= c1;
    end
  end

  // Stage 3: overlay product, dark and light halves share one multiplier.
  assign m2    = q2[26:19];
  assign c2_hi = (c2 >= ntob_pkg::NEUTRAL);
  assign mul_a = c2_hi ? {~c2[6:0], 1'b0} : {c2[6:0], 1'b0};
  assign mul_b = c2_hi ? ~m2 : m2;

  always_ff @(posedge clk) begin
    if (en) begin
      y3  <= 16'(16'(mul_a) * 16'(mul_b));
      hi3 <= c2_hi;
    end
  end

  // Stage 4: divide by 255 through the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      z4  <= 31'(31'(y3) * 31'(ntob_pkg::RECIP_255));
      hi4 <= hi3;
    end
  end

  // Light half mirrors the quotient around 255.
  assign quot = z4[30:23];
  assign r    = hi4 ? ~quot : quot;

endmodule

@@ src/noise_texture_overlay_blend_core.sv @@
// Top level of the noise texture overlay blend core.
//
//   Channel   Handshake               Payload
//   s_*       s_tvalid / s_tready     s_tuser: mode; s_tdata: col, row, pixel_in
//   m_*       m_tvalid / m_tready     m_tdata: pixel_out
//   APB       psel, penable, pready   paddr, pwdata, prdata: seven registers
//
// One item is taken per cycle while the pipeline is not held. A pixel passes
// through COORD_BITS stages in the pipelined texture modulo units, one
// texture memory read, four blend stages and the output register.
// Texel loads go down the same pipeline and write the memory in the lookup
// slot, so loads and lookups reach the single memory port in arrival order.
// When a result waits and m_tready is low, the whole pipeline holds.
// Reset is synchronous; the texture memory is not cleared.
module noise_texture_overlay_blend_core #(
  parameter int unsigned MAX_TEXTURE_SIDE = 256,
  parameter int unsigned COORD_BITS       = 12
) (
  input  logic clk,
  input  logic rst,

  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // Fields from bit 0: col, row, pixel_in, zero padding.
  input  logic [((2*COORD_BITS+32+7)/8)*8-1:0]    s_tdata,
  // Fields from bit 0: mode.
  input  logic                                    s_tuser,

  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // Fields from bit 0: pixel_out.
  output logic [31:0]                             m_tdata,

  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [ntob_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int unsigned CB         = COORD_BITS;
  localparam int unsigned SIDE_BITS  = (MAX_TEXTURE_SIDE > 1) ? $clog2(MAX_TEXTURE_SIDE) : 1;
  localparam int unsigned DIV_BITS   = $clog2(MAX_TEXTURE_SIDE + 1);
  localparam int unsigned DEPTH      = MAX_TEXTURE_SIDE * MAX_TEXTURE_SIDE;
  localparam int unsigned ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NB         = ntob_pkg::BLEND_STAGES;

  // Configuration registers.
  logic [6:0]  noise_percent;
  logic [8:0]  texture_width;
  logic [8:0]  texture_height;
  logic [12:0] clip_left;
  logic [12:0] clip_top;
  logic [12:0] clip_right;
  logic [12:0] clip_bottom;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_percent  <= 7'd0;
      texture_width  <= 9'd256;
      texture_height <= 9'd256;
      clip_left      <= 13'd0;
      clip_top       <= 13'd0;
      clip_right     <= 13'd4096;
      clip_bottom    <= 13'd4096;
    end else if (cfg_write) begin
      case (paddr[4:2])
        ntob_pkg::REG_NOISE_PERCENT:  noise_percent  <= pwdata[6:0];
        ntob_pkg::REG_TEXTURE_WIDTH:  texture_width  <= pwdata[8:0];
        ntob_pkg::REG_TEXTURE_HEIGHT: texture_height <= pwdata[8:0];
        ntob_pkg::REG_CLIP_LEFT:      clip_left      <= pwdata[12:0];
        ntob_pkg::REG_CLIP_TOP:       clip_top       <= pwdata[12:0];
        ntob_pkg::REG_CLIP_RIGHT:     clip_right     <= pwdata[12:0];
        ntob_pkg::REG_CLIP_BOTTOM:    clip_bottom    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[4:2])
      ntob_pkg::REG_NOISE_PERCENT:  prdata = {25'd0, noise_percent};
      ntob_pkg::REG_TEXTURE_WIDTH:  prdata = {23'd0, texture_width};
      ntob_pkg::REG_TEXTURE_HEIGHT: prdata = {23'd0, texture_height};
      ntob_pkg::REG_CLIP_LEFT:      prdata = {19'd0, clip_left};
      ntob_pkg::REG_CLIP_TOP:       prdata = {19'd0, clip_top};
      ntob_pkg::REG_CLIP_RIGHT:     prdata = {19'd0, clip_right};
      ntob_pkg::REG_CLIP_BOTTOM:    prdata = {19'd0, clip_bottom};
      default:                      prdata = 32'd0;
    endcase
  end

  // Effective strength and texture size after saturation.
  logic [6:0]          p_sat;
  logic [DIV_BITS-1:0] tw_clamp;
  logic [DIV_BITS-1:0] th_clamp;

  assign p_sat = (noise_percent > ntob_pkg::PCT_MAX) ? ntob_pkg::PCT_MAX : noise_percent;

  always_comb begin
    if (texture_width == 9'd0) begin
      tw_clamp = DIV_BITS'(1);
    end else if (32'(texture_width) > MAX_TEXTURE_SIDE) begin
      tw_clamp = DIV_BITS'(MAX_TEXTURE_SIDE);
    end else begin
      tw_clamp = DIV_BITS'(texture_width);
    end
    if (texture_height == 9'd0) begin
      th_clamp = DIV_BITS'(1);
    end else if (32'(texture_height) > MAX_TEXTURE_SIDE) begin
      th_clamp = DIV_BITS'(MAX_TEXTURE_SIDE);
    end else begin
      th_clamp = DIV_BITS'(texture_height);
    end
  end

  // Global advance: the pipeline moves unless a result waits untaken.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input unpacking and front-end decisions.
  logic [CB-1:0]        in_col;
  logic [CB-1:0]        in_row;
  logic [31:0]          in_pix;
  ntob_pkg::side_t      in_side;
  logic [ADDR_BITS-1:0] in_waddr;

  assign in_col = s_tdata[CB-1:0];
  assign in_row = s_tdata[2*CB-1:CB];
  assign in_pix = s_tdata[2*CB+31:2*CB];

  always_comb begin
    in_side.load    = !s_tuser;
    in_side.we      = !s_tuser && (32'(in_col) < MAX_TEXTURE_SIDE)
                      && (32'(in_row) < MAX_TEXTURE_SIDE);
    in_side.in_clip = (in_col >= clip_left) && (in_col < clip_right)
                      && (in_row >= clip_top) && (in_row < clip_bottom);
    in_side.pix     = in_pix;
  end

  assign in_waddr = ADDR_BITS'(32'(in_row) * MAX_TEXTURE_SIDE + 32'(in_col));

  // Tiling: column and row modulo the texture size.
  logic [SIDE_BITS-1:0] col_rem;
  logic [SIDE_BITS-1:0] row_rem;

  ntob_mod #(
    .DIVIDEND_BITS (CB),
    .DIVISOR_BITS  (DIV_BITS),
    .REM_BITS      (SIDE_BITS)
  ) u_col_mod (
    .clk       (clk),
    .en        (en),
    .dividend  (in_col),
    .divisor   (tw_clamp),
    .remainder (col_rem)
  );

  ntob_mod #(
    .DIVIDEND_BITS (CB),
    .DIVISOR_BITS  (DIV_BITS),
    .REM_BITS      (SIDE_BITS)
  ) u_row_mod (
    .clk       (clk),
    .en        (en),
    .dividend  (in_row),
    .divisor   (th_clamp),
    .remainder (row_rem)
  );

  // Side information delayed to match the modulo units.
  logic [CB-1:0]        vld_d;
  ntob_pkg::side_t      sb_d    [0:CB-1];
  logic [ADDR_BITS-1:0] waddr_d [0:CB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= '0;
    end else if (en) begin
      vld_d <= {vld_d[CB-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_d[0]    <= in_side;
      waddr_d[0] <= in_waddr;
      for (int i = 1; i < CB; i++) begin
        sb_d[i]    <= sb_d[i-1];
        waddr_d[i] <= waddr_d[i-1];
      end
    end
  end

  // Texture memory: one load or one lookup per cycle while the pipeline moves, read data registered.
  logic [23:0]          tex_mem [0:DEPTH-1];
  logic [23:0]          tex_rd;
  logic [ADDR_BITS-1:0] raddr;
  logic                 vld_m;
  ntob_pkg::side_t      sb_m;

  assign raddr = ADDR_BITS'(32'(row_rem) * MAX_TEXTURE_SIDE + 32'(col_rem));

  always_ff @(posedge clk) begin
    if (en) begin
      if (vld_d[CB-1] && sb_d[CB-1].we) begin
        tex_mem[waddr_d[CB-1]] <= sb_d[CB-1].pix[23:0];
      end
      tex_rd <= tex_mem[raddr];
      sb_m   <= sb_d[CB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
    end else if (en) begin
      vld_m <= vld_d[CB-1];
    end
  end

  // Three channel blend units: red, green, blue.
  logic [7:0] blend_r;
  logic [7:0] blend_g;
  logic [7:0] blend_b;

  ntob_blend u_blend_r (
    .clk (clk), .en (en), .p (p_sat),
    .c (sb_m.pix[23:16]), .n (tex_rd[23:16]), .r (blend_r)
  );

  ntob_blend u_blend_g (
    .clk (clk), .en (en), .p (p_sat),
    .c (sb_m.pix[15:8]), .n (tex_rd[15:8]), .r (blend_g)
  );

  ntob_blend u_blend_b (
    .clk (clk), .en (en), .p (p_sat),
    .c (sb_m.pix[7:0]), .n (tex_rd[7:0]), .r (blend_b)
  );

  // Side information delayed to match the blend stages.
  logic [NB-1:0]   vld_b;
  ntob_pkg::side_t sb_b [0:NB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= '0;
    end else if (en) begin
      vld_b <= {vld_b[NB-2:0], vld_m};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_b[0] <= sb_m;
      for (int i = 1; i < NB; i++) begin
        sb_b[i] <= sb_b[i-1];
      end
    end
  end

  // Output register: pixels only, texel loads are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld_b[NB-1] && !sb_b[NB-1].load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb_b[NB-1].in_clip) begin
        m_tdata <= {ntob_pkg::ALPHA_OPAQUE, blend_r, blend_g, blend_b};
      end else begin
        m_tdata <= sb_b[NB-1].pix;
      end
    end
  end

  // A waiting result holds the whole pipeline, input included.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while a result is stalled");

  // Tiled coordinates stay inside the texture for every lookup.
  a_col_in_texture: assert property (@(posedge clk) disable iff (rst)
    (vld_d[CB-1] && !sb_d[CB-1].load) |-> (col_rem < tw_clamp))
    else $error("column remainder not below texture width");

  a_row_in_texture: assert property (@(posedge clk) disable iff (rst)
    (vld_d[CB-1] && !sb_d[CB-1].load) |-> (row_rem < th_clamp))
    else $error("row remainder not below texture height");

  // No result comes out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

@@ tb/noise_texture_overlay_blend_core_tb.sv @@
// Self-checking testbench for the noise texture overlay blend core.
module noise_texture_overlay_blend_core_tb;

  localparam int unsigned TEX_SIDE   = 256;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SDATA_W    = ((2*COORD_W+32+7)/8)*8;
  localparam int unsigned LATENCY    = COORD_W + 6;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned PHASES     = 10;
  localparam int unsigned PHASE_PIX  = 85;
  localparam logic        MODE_LOAD  = 1'b0;
  localparam logic        MODE_PIXEL = 1'b1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [SDATA_W-1:0] s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ntob_pkg::APB_ADDR_BITS-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  noise_texture_overlay_blend_core #(
    .MAX_TEXTURE_SIDE(TEX_SIDE),
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block state used to work out each blended pixel.
  logic [23:0] texel_store [0:TEX_SIDE*TEX_SIDE-1];
  bit          texel_loaded [0:TEX_SIDE*TEX_SIDE-1];
  logic [6:0]  cfg_pct    = 7'd0;
  logic [8:0]  cfg_width  = 9'd256;
  logic [8:0]  cfg_height = 9'd256;
  logic [12:0] cfg_left   = 13'd0;
  logic [12:0] cfg_top    = 13'd0;
  logic [12:0] cfg_right  = 13'd4096;
  logic [12:0] cfg_bottom = 13'd4096;

  logic [31:0] pending_pixels [$];
  logic [31:0] want_pixel;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_style = 0;
  int unsigned stall_left = 0;

  // Texture sides out of range are clamped the same way the block does.
  function automatic int unsigned tex_side(input logic [8:0] side);
    if (side == 0) return 1;
    if (side > TEX_SIDE) return TEX_SIDE;
    return side;
  endfunction

  function automatic bit inside_clip(input logic [11:0] col, input logic [11:0] row);
    return ({1'b0, col} >= cfg_left) && ({1'b0, col} < cfg_right) &&
           ({1'b0, row} >= cfg_top) && ({1'b0, row} < cfg_bottom);
  endfunction

  function automatic int unsigned texel_index(input logic [11:0] col, input logic [11:0] row);
    return (row % tex_side(cfg_height)) * TEX_SIDE + (col % tex_side(cfg_width));
  endfunction

  // One channel: pull the noise toward grey, then overlay it on the pixel.
  function automatic logic [7:0] overlay_channel(input logic [7:0] base, input logic [7:0] noise,
                                                 input int unsigned pct);
    int unsigned c;
    int unsigned n;
    int unsigned grey;
    int unsigned mixed;
    c = base;
    n = noise;
    grey = (n * pct + 128 * (100 - pct)) / 100;
    if (grey > 255) grey = 255;
    if (c < 128) mixed = (2 * c * grey) / 255;
    else mixed = 255 - (2 * (255 - c) * (255 - grey)) / 255;
    if (mixed > 255) mixed = 255;
    return mixed[7:0];
  endfunction

  function automatic logic [31:0] overlay_pixel(input logic [11:0] col, input logic [11:0] row,
                                                input logic [31:0] pix);
    logic [23:0] tex;
    int unsigned pct;
    if (!inside_clip(col, row)) return pix;
    tex = texel_store[texel_index(col, row)];
    pct = (cfg_pct > ntob_pkg::PCT_MAX) ? ntob_pkg::PCT_MAX : cfg_pct;
    return {ntob_pkg::ALPHA_OPAQUE,
            overlay_channel(pix[23:16], tex[23:16], pct),
            overlay_channel(pix[15:8], tex[15:8], pct),
            overlay_channel(pix[7:0], tex[7:0], pct)};
  endfunction

  // Channels favor the blend's breakpoints and extremes a quarter of the time.
  function automatic logic [7:0] pick_channel();
    if ($urandom_range(0, 3) != 0) return 8'($urandom);
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_pixel();
    return {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
  endfunction

  // A coordinate at or just around a clip bound pair.
  function automatic logic [11:0] pick_near(input logic [12:0] lo, input logic [12:0] hi);
    int lo_i;
    int hi_i;
    lo_i = int'(lo) - 2;
    hi_i = int'(hi) + 1;
    if (lo_i < 0) lo_i = 0;
    if (hi_i > 4095) hi_i = 4095;
    if (lo_i > hi_i) return 12'($urandom);
    return 12'($urandom_range(lo_i, hi_i));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s, got %h, expected %h", cycle_count, what, got, want);
  endtask

  // Register write over the configuration port; the shadow copy follows it.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      ntob_pkg::REG_NOISE_PERCENT:  cfg_pct = value[6:0];
      ntob_pkg::REG_TEXTURE_WIDTH:  cfg_width = value[8:0];
      ntob_pkg::REG_TEXTURE_HEIGHT: cfg_height = value[8:0];
      ntob_pkg::REG_CLIP_LEFT:      cfg_left = value[12:0];
      ntob_pkg::REG_CLIP_TOP:       cfg_top = value[12:0];
      ntob_pkg::REG_CLIP_RIGHT:     cfg_right = value[12:0];
      ntob_pkg::REG_CLIP_BOTTOM:    cfg_bottom = value[12:0];
      default: ;
    endcase
  endtask

  task automatic write_clip(input int unsigned left, input int unsigned top,
                            input int unsigned right, input int unsigned bottom);
    write_reg(ntob_pkg::REG_CLIP_LEFT, left);
    write_reg(ntob_pkg::REG_CLIP_TOP, top);
    write_reg(ntob_pkg::REG_CLIP_RIGHT, right);
    write_reg(ntob_pkg::REG_CLIP_BOTTOM, bottom);
  endtask

  // Send one item, with a random gap whenever a burst runs out.
  task automatic send_item(input logic mode, input logic [11:0] col, input logic [11:0] row,
                           input logic [31:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = mode;
    s_tdata = {pix, row, col};
    do @(posedge clk); while (!s_tready);
    // The item is accepted: update the shadow texture or queue the result.
    if (mode == MODE_LOAD) begin
      if (col < TEX_SIDE && row < TEX_SIDE) begin
        texel_store[row * TEX_SIDE + col] = pix[23:0];
        texel_loaded[row * TEX_SIDE + col] = 1'b1;
      end
    end else begin
      pending_pixels.push_back(overlay_pixel(col, row, pix));
    end
  endtask

  // A pixel inside the window only ever reads a texel that was loaded first.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [31:0] pix);
    int unsigned tcol;
    int unsigned trow;
    if (inside_clip(col, row) && !texel_loaded[texel_index(col, row)]) begin
      tcol = col % tex_side(cfg_width);
      trow = row % tex_side(cfg_height);
      send_item(MODE_LOAD, 12'(tcol), 12'(trow), $urandom);
    end
    send_item(MODE_PIXEL, col, row, pix);
  endtask

  // Wait until the pipeline has drained before touching the registers.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_reset_state();
    // Reset strength is zero, so every blend uses neutral grey.
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_pixel(12'd128, 12'd77, 32'h1280_7F00);
    settle();
  endtask

  task automatic test_blend_extremes();
    write_reg(ntob_pkg::REG_NOISE_PERCENT, 100);
    write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 2);
    write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 2);
    send_item(MODE_LOAD, 12'd0, 12'd0, 32'hFF00_0000);
    send_item(MODE_LOAD, 12'd1, 12'd0, 32'h00FF_FFFF);
    send_item(MODE_LOAD, 12'd0, 12'd1, 32'h5580_7F80);
    send_item(MODE_LOAD, 12'd1, 12'd1, 32'hAA7F_807F);
    send_pixel(12'd0, 12'd0, 32'h007F_80FF);
    send_pixel(12'd1, 12'd0, 32'hFF00_FF80);
    send_pixel(12'd2, 12'd1, 32'h807F_00FF);
    send_pixel(12'd3, 12'd3, 32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_out_of_range_loads();
    write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 256);
    write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 256);
    send_item(MODE_LOAD, 12'd0, 12'd0, 32'h0012_3456);
    send_item(MODE_LOAD, 12'd0, 12'd1, 32'h00AB_CDEF);
    // Loads past the texture are dropped; the first two would alias onto the texels above.
    send_item(MODE_LOAD, 12'd256, 12'd0, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 12'd0, 12'd256, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0, 32'h4040_C0C0);
    send_pixel(12'd0, 12'd1, 32'h4040_C0C0);
    settle();
  endtask

  task automatic test_register_limits();
    // Strength above 100 saturates; a zero side acts as one, a large side as 256.
    write_reg(ntob_pkg::REG_NOISE_PERCENT, 127);
    write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 0);
    write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 511);
    send_pixel(12'd7, 12'd300, 32'h3355_AACC);
    send_pixel(12'd4095, 12'd255, 32'h80FF_0080);
    settle();
    write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 300);
    write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 0);
    send_pixel(12'd300, 12'd9, 32'hC0C0_4040);
    settle();
  endtask

  task automatic test_clip_window();
    write_reg(ntob_pkg::REG_NOISE_PERCENT, 50);
    write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 8);
    write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 8);
    write_clip(10, 20, 30, 40);
    // Each edge of the window, just inside and just outside.
    send_pixel(12'd9, 12'd20, 32'h1122_3344);
    send_pixel(12'd10, 12'd20, 32'h1122_3344);
    send_pixel(12'd29, 12'd39, 32'h5566_7788);
    send_pixel(12'd30, 12'd39, 32'h5566_7788);
    send_pixel(12'd10, 12'd40, 32'h99AA_BBCC);
    send_pixel(12'd10, 12'd19, 32'h99AA_BBCC);
    settle();
    // An empty window lets every pixel through.
    write_clip(30, 20, 30, 40);
    send_pixel(12'd30, 12'd25, 32'h0102_0304);
    settle();
  endtask

  // Register settings for one random phase; the first few are the extremes.
  task automatic pick_settings(input int unsigned phase);
    int unsigned left;
    int unsigned top;
    case (phase)
      0: begin
        write_reg(ntob_pkg::REG_NOISE_PERCENT, 100);
        write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 256);
        write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 256);
        write_clip(0, 0, 4096, 4096);
      end
      1: begin
        write_reg(ntob_pkg::REG_NOISE_PERCENT, 0);
        write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 1);
        write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 1);
        write_clip(0, 0, 8191, 8191);
      end
      2: begin
        write_reg(ntob_pkg::REG_NOISE_PERCENT, 127);
        write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 0);
        write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 511);
        write_clip(4095, 4095, 4096, 4096);
      end
      3: begin
        write_reg(ntob_pkg::REG_NOISE_PERCENT, $urandom_range(0, 100));
        write_reg(ntob_pkg::REG_TEXTURE_WIDTH, 16);
        write_reg(ntob_pkg::REG_TEXTURE_HEIGHT, 3);
        left = $urandom_range(0, 4096);
        write_clip(left, 0, $urandom_range(0, left), 4096);
      end
      default: begin
        write_reg(ntob_pkg::REG_NOISE_PERCENT,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127)
                                              : $urandom_range(0, 100));
        write_reg(ntob_pkg::REG_TEXTURE_WIDTH,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(1, 32));
        write_reg(ntob_pkg::REG_TEXTURE_HEIGHT,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(1, 32));
        left = $urandom_range(0, 300);
        top = $urandom_range(0, 300);
        write_clip(left, top,
                   ($urandom_range(0, 4) == 0) ? 4096 : left + $urandom_range(1, 400),
                   ($urandom_range(0, 4) == 0) ? 8191 : top + $urandom_range(1, 400));
      end
    endcase
  endtask

  task automatic test_random_mix();
    int unsigned phase;
    int unsigned sent;
    int unsigned pick;
    logic [11:0] col;
    logic [11:0] row;
    for (phase = 0; phase < PHASES; phase++) begin
      pick_settings(phase);
      sent = 0;
      while (sent < PHASE_PIX) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Stray loads; each coordinate is half the time inside the texture, half the time random.
          col = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 255)) : 12'($urandom);
          row = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 255)) : 12'($urandom);
          send_item(MODE_LOAD, col, row, $urandom);
        end else begin
          if (pick < 18) begin
            col = 12'($urandom);
            row = 12'($urandom);
          end else begin
            col = pick_near(cfg_left, cfg_right);
            row = pick_near(cfg_top, cfg_bottom);
          end
          send_pixel(col, row, pick_pixel());
          sent++;
        end
      end
      settle();
    end
  endtask

  // The receiver switches between stall styles every so often.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0: m_tready = 1'b1;
      1: m_tready = 1'($urandom_range(0, 1));
      2: m_tready = ($urandom_range(0, 9) != 0);
      default: m_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each delivered pixel with the oldest one still owed.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with none pending", m_tdata, 32'h0);
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (m_tdata !== want_pixel) report_mismatch("pixel_out", m_tdata, want_pixel);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_blend_extremes();
    test_out_of_range_loads();
    test_register_limits();
    test_clip_window();
    test_random_mix();
    settle();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
